// ===== hw/rtl/cda_pkg.sv =====
// Shared types, constants and the month length table for the date adder.
// No dependencies; used by cda_ctrl, cda_datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package cda_pkg;

   // Configuration of the calendar walk
   localparam int MAX_YEAR        = 9999;
   localparam int OFFSET_BITS     = 16;
   localparam int LEAP_PERIOD     = 4;
   localparam int MONTHS          = 12;
   localparam int DAYS_PER_PERIOD = 1461;

   // Fixed field widths of the item
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;

   // Day accumulator: start day plus signed offset, and room for a whole period
   localparam int D_BITS = (OFFSET_BITS + 2 > 13) ? OFFSET_BITS + 2 : 13;

   // Working year: start year plus the years an offset can span, plus sign
   localparam int YEAR_BASE_BITS =
      ($clog2(MAX_YEAR + 1) > YEAR_W) ? $clog2(MAX_YEAR + 1) : YEAR_W;
   localparam int YEAR_BITS =
      ((YEAR_BASE_BITS > OFFSET_BITS - 8) ? YEAR_BASE_BITS : OFFSET_BITS - 8) + 2;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic step;
   } cda_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic input_bad;
      logic walk_done;
   } cda_status_type;

   // Days in a month; zero for a month code outside 1..12
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      len = '0;
      case (m) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = '0;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/calendar_date_add_days_unit.sv =====
// Date adder: start date plus signed day offset, one item at a time.
// Each accepted item walks in 4-year period steps, then month steps (one per cycle);
// an invalid start date skips the walk. A new item is accepted only in idle, after the
// result of the last one has been taken.
// Reset (synchronous, active high) returns the controller to idle; no item in flight.
`timescale 1ns / 1ps
`default_nettype none

module calendar_date_add_days_unit
   import cda_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [DAY_W-1:0]       req_day_in,
   input  wire logic [MONTH_W-1:0]     req_month_in,
   input  wire logic [YEAR_W-1:0]      req_year_in,
   input  wire logic [OFFSET_BITS-1:0] req_day_offset,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [DAY_W-1:0]            rsp_day_out,
   output logic [MONTH_W-1:0]          rsp_month_out,
   output logic [YEAR_W-1:0]           rsp_year_out,
   output logic                        rsp_input_invalid,
   output logic                        rsp_year_out_of_range
);

   cda_cmd_type    cmd;
   cda_status_type status;

   // Sequencer
   cda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Date registers and step logic
   cda_datapath u_datapath (
      .clock                 (clock),
      .req_day_in            (req_day_in),
      .req_month_in          (req_month_in),
      .req_year_in           (req_year_in),
      .req_day_offset        (req_day_offset),
      .cmd                   (cmd),
      .status                (status),
      .rsp_day_out           (rsp_day_out),
      .rsp_month_out         (rsp_month_out),
      .rsp_year_out          (rsp_year_out),
      .rsp_input_invalid     (rsp_input_invalid),
      .rsp_year_out_of_range (rsp_year_out_of_range)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/cda_ctrl.sv =====
// Controller for the date adder: takes an item, runs the walk, hands out the result.
// Depends on cda_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module cda_ctrl
   import cda_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   input  wire cda_status_type status,
   output cda_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (status.input_bad || status.walk_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/cda_datapath.sv =====
// Datapath for the date adder: day, month and year registers and the step logic.
// Depends on cda_pkg for widths, constants and the month length table.
`timescale 1ns / 1ps
`default_nettype none

module cda_datapath
   import cda_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic [DAY_W-1:0]       req_day_in,
   input  wire logic [MONTH_W-1:0]     req_month_in,
   input  wire logic [YEAR_W-1:0]      req_year_in,
   input  wire logic [OFFSET_BITS-1:0] req_day_offset,
   input  wire cda_cmd_type            cmd,
   output cda_status_type              status,
   output logic [DAY_W-1:0]            rsp_day_out,
   output logic [MONTH_W-1:0]          rsp_month_out,
   output logic [YEAR_W-1:0]           rsp_year_out,
   output logic                        rsp_input_invalid,
   output logic                        rsp_year_out_of_range
);

   localparam logic signed [D_BITS-1:0]    PERIOD_D   = D_BITS'(DAYS_PER_PERIOD);
   localparam logic signed [D_BITS-1:0]    NPERIOD_D  = -D_BITS'(DAYS_PER_PERIOD);
   localparam logic signed [D_BITS-1:0]    ONE_D      = D_BITS'(1);
   localparam logic signed [YEAR_BITS-1:0] MAX_YEAR_Y = YEAR_BITS'(MAX_YEAR);
   localparam logic signed [YEAR_BITS-1:0] ONE_Y      = YEAR_BITS'(1);
   localparam logic signed [YEAR_BITS-1:0] PERIOD_Y   = YEAR_BITS'(LEAP_PERIOD);
   localparam logic [MONTH_W-1:0]          LAST_MONTH = MONTH_W'(MONTHS);
   localparam logic [MONTH_W-1:0]          FIRST_MONTH = MONTH_W'(1);

   logic signed [D_BITS-1:0]    day_ff, day_in;
   logic [MONTH_W-1:0]          month_ff, month_in;
   logic signed [YEAR_BITS-1:0] year_ff, year_in;
   logic                        bad_ff, bad_in;

   logic [DAY_W-1:0]            start_len;
   logic                        start_bad;
   logic [YEAR_BITS-1:0]        start_year;
   logic signed [D_BITS-1:0]    start_day;

   logic [DAY_W-1:0]            len_cur, len_prev;
   logic [MONTH_W-1:0]          month_prev, month_next;
   logic signed [YEAR_BITS-1:0] year_prev, year_next;
   logic signed [D_BITS-1:0]    len_cur_d, len_prev_d;
   logic                        go_period_fwd, go_period_bwd, go_month_fwd, go_month_bwd;
   logic                        range_bad;

   // Start date check and first day sum
   always_comb begin
      start_year = {{(YEAR_BITS-YEAR_W){1'b0}}, req_year_in};
      start_len  = month_len(req_month_in, req_year_in[1:0] == 2'b00);
      start_bad  = (req_month_in == '0) || (req_month_in > LAST_MONTH) ||
                   (start_year == '0) || ($signed(start_year) > MAX_YEAR_Y) ||
                   (req_day_in == '0) || (req_day_in > start_len);
      start_day  = $signed({{(D_BITS-DAY_W){1'b0}}, req_day_in}) +
                   $signed({{(D_BITS-OFFSET_BITS){req_day_offset[OFFSET_BITS-1]}},
                            req_day_offset});
   end

   // Neighbor months and their lengths
   always_comb begin
      month_next = (month_ff == LAST_MONTH) ? FIRST_MONTH : month_ff + MONTH_W'(1);
      year_next  = (month_ff == LAST_MONTH) ? year_ff + ONE_Y : year_ff;
      month_prev = (month_ff == FIRST_MONTH) ? LAST_MONTH : month_ff - MONTH_W'(1);
      year_prev  = (month_ff == FIRST_MONTH) ? year_ff - ONE_Y : year_ff;
      len_cur    = month_len(month_ff, year_ff[1:0] == 2'b00);
      len_prev   = month_len(month_prev, year_prev[1:0] == 2'b00);
      len_cur_d  = $signed({{(D_BITS-DAY_W){1'b0}}, len_cur});
      len_prev_d = $signed({{(D_BITS-DAY_W){1'b0}}, len_prev});
   end

   // Which step applies this cycle, in walk order
   always_comb begin
      go_period_fwd = day_ff > PERIOD_D;
      go_period_bwd = !go_period_fwd && (day_ff < NPERIOD_D);
      go_month_fwd  = !go_period_fwd && !go_period_bwd && (day_ff > len_cur_d);
      go_month_bwd  = !go_period_fwd && !go_period_bwd && !go_month_fwd &&
                      (day_ff < ONE_D);
      status.walk_done = !(go_period_fwd || go_period_bwd || go_month_fwd || go_month_bwd);
      status.input_bad = bad_ff;
   end

   // Register updates: load a new item or take one step
   always_comb begin
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      bad_in   = bad_ff;
      if (cmd.load) begin
         day_in   = start_day;
         month_in = req_month_in;
         year_in  = $signed(start_year);
         bad_in   = start_bad;
      end else if (cmd.step) begin
         if (go_period_fwd) begin
            day_in  = day_ff - PERIOD_D;
            year_in = year_ff + PERIOD_Y;
         end else if (go_period_bwd) begin
            day_in  = day_ff + PERIOD_D;
            year_in = year_ff - PERIOD_Y;
         end else if (go_month_fwd) begin
            day_in   = day_ff - len_cur_d;
            month_in = month_next;
            year_in  = year_next;
         end else if (go_month_bwd) begin
            day_in   = day_ff + len_prev_d;
            month_in = month_prev;
            year_in  = year_prev;
         end
      end
   end

   always_ff @(posedge clock) begin
      day_ff   <= day_in;
      month_ff <= month_in;
      year_ff  <= year_in;
      bad_ff   <= bad_in;
   end

   // Result fields; zero date when the start or the result is out of bounds
   always_comb begin
      range_bad             = (year_ff < ONE_Y) || (year_ff > MAX_YEAR_Y);
      rsp_input_invalid     = bad_ff;
      rsp_year_out_of_range = !bad_ff && range_bad;
      if (bad_ff || range_bad) begin
         rsp_day_out   = '0;
         rsp_month_out = '0;
         rsp_year_out  = '0;
      end else begin
         rsp_day_out   = day_ff[DAY_W-1:0];
         rsp_month_out = month_ff;
         rsp_year_out  = year_ff[YEAR_W-1:0];
      end
   end

endmodule

`default_nettype wire
